// ----- rtl/core/tridiagonal_system_solver_macros.svh -----
// ----------------------------------------------------------------------------
// Tridiagonal solver assertion macros
// Shared property wrappers for the solver's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_MACROS_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TDS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tds check failed");

// next-cycle implication, disabled while in reset
`define TDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tds check failed");

`endif

// ----- rtl/core/tds_pkg.sv -----
// ----------------------------------------------------------------------------
// tds_pkg
// Sizes, status codes and saturating fixed-point helpers of the solver.
// ----------------------------------------------------------------------------
`default_nettype none

package tds_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int FRAC_BITS = 16;

  localparam int IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int NUM_W  = 32 + FRAC_BITS;      // dividend magnitude width
  localparam int DCNT_W = $clog2(NUM_W + 1);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  // product >> FRAC_BITS (floor), clamped to 32 bits
  function automatic sat_t mul_sat(input logic signed [63:0] p);
    logic signed [63:0] s;
    sat_t r;
    s = p >>> FRAC_BITS;
    r.ovf = (s[63:31] != {33{s[31]}});
    r.val = r.ovf ? (s[63] ? Q_MIN : Q_MAX) : s[31:0];
    return r;
  endfunction

  function automatic sat_t sub_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    sat_t r;
    d = {a[31], a} - {b[31], b};
    r.ovf = d[32] ^ d[31];
    r.val = r.ovf ? (d[32] ? Q_MIN : Q_MAX) : d[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tridiagonal_system_solver.sv -----
// ----------------------------------------------------------------------------
// tridiagonal_system_solver
// Thomas-algorithm solver for signed Q16.16 tridiagonal systems.
// ----------------------------------------------------------------------------
// Rows load one word per cycle while in_tready is high; the word with tlast
// set starts the solve and the block drops in_tready until the last solution
// word is taken. Solve time is set by the shared shift-subtract divider,
// which retires one quotient bit per cycle of a 32+FRAC_BITS = 48-bit quotient
// and runs three times per row (forward rate, backward rate, final quotient),
// plus the time to emit the results and the backpressure on the output.
// A zero divisor skips its division.
// Status is 1 for a zero pivot, else 2 for any saturation, else 0, and is
// the same on every solution word of a system.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tridiagonal_system_solver_macros.svh"

module tridiagonal_system_solver
  import tds_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,  // sub_diag, main_diag, super_diag, rhs_value
  input  wire logic         in_tlast,  // last_row
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [39:0]       out_tdata, // solution, row_index, zero pad
  output logic              out_tlast, // last_result
  output logic [1:0]        out_tuser  // status
);

  typedef enum logic [4:0] {
    S_IDLE, S_P0_RD, S_P0_LD,
    S_F_RD, S_F_LD, S_F_M1, S_F_M2, S_F_M3, S_F_WB,
    S_B_RD, S_B_LD, S_B_M1, S_B_M2, S_B_WB,
    S_Q_RD, S_Q_LD, S_Q_WB,
    S_DIV,
    S_O_RD, S_O_LD, S_O_SEND
  } state_t;

  typedef enum logic [1:0] {P_FWD, P_BWD, P_QUO} pass_t;

  state_t state_r;
  pass_t  pass_r;

  logic [31:0] sub_mem   [MAX_ROWS];
  logic [31:0] diag_mem  [MAX_ROWS];
  logic [31:0] super_mem [MAX_ROWS];
  logic [31:0] rhs_mem   [MAX_ROWS];
  logic [31:0] sub_q, diag_q, super_q, rhs_q;

  logic [CNT_W-1:0] rows_loaded_r, n_r;
  logic [IDX_W-1:0] idx_r;
  logic [1:0]       flags_r;   // bit0 zero pivot, bit1 saturation

  logic [31:0] pd_r, ps_r, pr_r;      // previous row
  logic [31:0] cur_d_r, cur_r_r;      // row being reduced
  logic [31:0] rate_r;
  logic signed [63:0] prod_r;

  logic [NUM_W-1:0]  qn_r;
  logic [32:0]       rem_r;
  logic [31:0]       den_r;
  logic              neg_r;
  logic [DCNT_W-1:0] dcnt_r;

  logic [31:0] out_sol_r;
  logic [5:0]  out_idx_r;
  logic        out_last_r, out_tvalid_r;
  logic [1:0]  out_stat_r;

  // ---- load side
  logic             in_acc;
  logic [IDX_W-1:0] slot;
  logic [CNT_W-1:0] cnt_inc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot      = (rows_loaded_r < CNT_W'(MAX_ROWS)) ? rows_loaded_r[IDX_W-1:0]
                                                        : IDX_W'(MAX_ROWS - 1);
  assign cnt_inc   = (rows_loaded_r < CNT_W'(MAX_ROWS)) ? rows_loaded_r + 1'b1
                                                        : rows_loaded_r;

  // ---- memory ports
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             diag_we, rhs_we;
  logic [31:0]      diag_wd, rhs_wd;

  always_comb begin
    case (state_r)
      S_P0_RD: rd_addr = '0;
      S_B_RD:  rd_addr = idx_r - 1'b1;
      default: rd_addr = idx_r;
    endcase
  end

  always_comb begin
    wr_addr = idx_r;
    diag_we = 1'b0;
    rhs_we  = 1'b0;
    diag_wd = cur_d_r;
    rhs_wd  = cur_r_r;
    case (state_r)
      S_IDLE: begin
        wr_addr = slot;
        diag_we = in_acc;
        rhs_we  = in_acc;
        diag_wd = in_tdata[63:32];
        rhs_wd  = in_tdata[127:96];
      end
      S_F_WB: begin
        diag_we = 1'b1;
        rhs_we  = 1'b1;
      end
      S_B_WB: begin
        wr_addr = idx_r - 1'b1;
        rhs_we  = 1'b1;
      end
      S_Q_WB: begin
        rhs_we = 1'b1;
        rhs_wd = rate_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sub_mem[slot]   <= in_tdata[31:0];
      super_mem[slot] <= in_tdata[95:64];
    end
    sub_q   <= sub_mem[rd_addr];
    super_q <= super_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (diag_we)
      diag_mem[wr_addr] <= diag_wd;
    diag_q <= diag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rhs_we)
      rhs_mem[wr_addr] <= rhs_wd;
    rhs_q <= rhs_mem[rd_addr];
  end

  // ---- shared arithmetic
  logic [31:0] div_a, div_b, a_mag, b_mag;
  sat_t        ms, ss;
  logic [31:0] sub_a, mul_b;

  always_comb begin
    case (state_r)
      S_F_LD:  begin div_a = sub_q;   div_b = pd_r;   end
      S_B_LD:  begin div_a = super_q; div_b = pd_r;   end
      default: begin div_a = rhs_q;   div_b = diag_q; end
    endcase
  end

  assign a_mag = div_a[31] ? (~div_a + 1'b1) : div_a;
  assign b_mag = div_b[31] ? (~div_b + 1'b1) : div_b;

  assign mul_b = (state_r == S_F_M1) ? ps_r : pr_r;
  assign ms    = mul_sat(prod_r);
  assign sub_a = (state_r == S_F_M2) ? cur_d_r : cur_r_r;
  assign ss    = sub_sat(sub_a, ms.val);

  // restoring divider step
  logic [32:0]        rem_sh;
  logic               q_bit;
  logic [NUM_W-1:0]   q_fin;
  logic [NUM_W-32:0]  q_hi;
  logic               q_ovf;
  logic [31:0]        q_val;

  assign rem_sh = {rem_r[31:0], qn_r[NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_r});
  assign q_fin  = {qn_r[NUM_W-2:0], q_bit};
  assign q_hi   = q_fin[NUM_W-1:31];
  assign q_ovf  = neg_r ? ((q_hi > (NUM_W-31)'(1)) ||
                           ((q_hi == (NUM_W-31)'(1)) && (q_fin[30:0] != '0)))
                        : (q_hi != '0);
  assign q_val  = q_ovf ? (neg_r ? Q_MIN : Q_MAX)
                        : (neg_r ? (~q_fin[31:0] + 1'b1) : q_fin[31:0]);

  state_t div_ret;
  always_comb begin
    case (pass_r)
      P_FWD:   div_ret = S_F_M1;
      P_BWD:   div_ret = S_B_M1;
      default: div_ret = S_Q_WB;
    endcase
  end

  // ---- sequencer
  always_ff @(posedge clk) begin
    prod_r <= $signed(rate_r) * $signed(mul_b);
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pass_r        <= P_FWD;
      rows_loaded_r <= '0;
      n_r           <= '0;
      idx_r         <= '0;
      flags_r       <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            rows_loaded_r <= cnt_inc;
            if (in_tlast) begin
              n_r           <= cnt_inc;
              rows_loaded_r <= '0;
              state_r       <= S_P0_RD;
            end
          end
        end
        S_P0_RD: state_r <= S_P0_LD;
        S_P0_LD: begin
          pd_r <= diag_q;
          ps_r <= super_q;
          pr_r <= rhs_q;
          if (n_r > CNT_W'(1)) begin
            idx_r   <= IDX_W'(1);
            state_r <= S_F_RD;
          end else begin
            idx_r   <= '0;
            state_r <= S_Q_RD;
          end
        end

        // forward elimination
        S_F_RD: state_r <= S_F_LD;
        S_F_LD, S_B_LD, S_Q_LD: begin
          cur_d_r <= diag_q;
          cur_r_r <= rhs_q;
          if (state_r == S_F_LD) begin
            pass_r <= P_FWD;
          end else if (state_r == S_B_LD) begin
            pass_r <= P_BWD;
          end else begin
            pass_r <= P_QUO;
          end
          if (div_b == '0) begin
            flags_r[0] <= 1'b1;
            rate_r     <= '0;
            case (state_r)
              S_F_LD:  state_r <= S_F_M1;
              S_B_LD:  state_r <= S_B_M1;
              default: state_r <= S_Q_WB;
            endcase
          end else begin
            qn_r    <= {a_mag, {FRAC_BITS{1'b0}}};
            rem_r   <= '0;
            den_r   <= b_mag;
            neg_r   <= div_a[31] ^ div_b[31];
            dcnt_r  <= DCNT_W'(NUM_W);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= q_bit ? (rem_sh - {1'b0, den_r}) : rem_sh;
          qn_r   <= q_fin;
          dcnt_r <= dcnt_r - 1'b1;
          if (dcnt_r == DCNT_W'(1)) begin
            rate_r <= q_val;
            if (q_ovf)
              flags_r[1] <= 1'b1;
            state_r <= div_ret;
          end
        end
        S_F_M1: state_r <= S_F_M2;
        S_F_M2: begin
          cur_d_r <= ss.val;
          if (ms.ovf || ss.ovf)
            flags_r[1] <= 1'b1;
          state_r <= S_F_M3;
        end
        S_F_M3: begin
          cur_r_r <= ss.val;
          if (ms.ovf || ss.ovf)
            flags_r[1] <= 1'b1;
          state_r <= S_F_WB;
        end
        S_F_WB: begin
          pd_r <= cur_d_r;
          ps_r <= super_q;
          pr_r <= cur_r_r;
          if (CNT_W'(idx_r) + 1'b1 == n_r) begin
            state_r <= S_B_RD;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_F_RD;
          end
        end

        // backward elimination; pd/pr hold row idx
        S_B_RD: state_r <= S_B_LD;
        S_B_M1: state_r <= S_B_M2;
        S_B_M2: begin
          cur_r_r <= ss.val;
          if (ms.ovf || ss.ovf)
            flags_r[1] <= 1'b1;
          state_r <= S_B_WB;
        end
        S_B_WB: begin
          pd_r <= cur_d_r;
          pr_r <= cur_r_r;
          if (idx_r == IDX_W'(1)) begin
            idx_r   <= '0;
            state_r <= S_Q_RD;
          end else begin
            idx_r   <= idx_r - 1'b1;
            state_r <= S_B_RD;
          end
        end

        // final quotients
        S_Q_RD: state_r <= S_Q_LD;
        S_Q_WB: begin
          if (CNT_W'(idx_r) + 1'b1 == n_r) begin
            idx_r   <= '0;
            state_r <= S_O_RD;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_Q_RD;
          end
        end

        // emit
        S_O_RD: state_r <= S_O_LD;
        S_O_LD: begin
          out_sol_r    <= rhs_q;
          out_idx_r    <= 6'(idx_r);
          out_last_r   <= (CNT_W'(idx_r) + 1'b1 == n_r);
          out_stat_r   <= flags_r[0] ? ST_ZERO : (flags_r[1] ? ST_SAT : ST_OK);
          out_tvalid_r <= 1'b1;
          state_r      <= S_O_SEND;
        end
        S_O_SEND: begin
          if (out_tready) begin
            out_tvalid_r <= 1'b0;
            if (out_last_r) begin
              flags_r <= '0;
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_O_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_idx_r, out_sol_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_stat_r;

  // ---- checks
  `TDS_ASSERT_NOW(a_no_load_while_out, clk, rst_n, in_tready, !out_tvalid_r)
  `TDS_ASSERT_NOW(a_rows_bounded, clk, rst_n, 1'b1, rows_loaded_r <= CNT_W'(MAX_ROWS))
  `TDS_ASSERT_NEXT(a_busy_after_last, clk, rst_n, in_acc && in_tlast, !in_tready)
  `TDS_ASSERT_NOW(a_last_on_final, clk, rst_n, out_tvalid_r,
                  out_last_r == (CNT_W'(idx_r) + 1'b1 == n_r))

endmodule

`default_nettype wire

// ----- test/tb_tridiagonal_system_solver.sv -----
// ----------------------------------------------------------------------------
// tb_tridiagonal_system_solver
// Self-checking bench for the Q16.16 tridiagonal solver.
// ----------------------------------------------------------------------------
// Rows go in as words and are mirrored in a software solver. When a system
// closes, every expected solution word is queued. Each word out is checked
// against the oldest entry. The sender runs in bursts and the receiver stalls.
// Runs cover single rows, zero pivots, saturation and field extremes. They
// also cover systems past the row limit and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tridiagonal_system_solver
  import tds_pkg::*;
();

  typedef struct {
    logic [31:0] solution;
    logic [5:0]  row_index;
    logic        last_result;
    logic [1:0]  status;
  } solution_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // sub_diag, main_diag, super_diag, rhs_value
  logic         in_tlast;   // last_row
  logic         out_tvalid;
  logic         out_tready;
  logic [39:0]  out_tdata;  // solution, row_index, zero pad
  logic         out_tlast;  // last_result
  logic [1:0]   out_tuser;  // status

  tridiagonal_system_solver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  localparam int IDLE_LIMIT = 60000;

  // mirror of the solver state
  logic signed [31:0] m_sub   [MAX_ROWS];
  logic signed [31:0] m_diag  [MAX_ROWS];
  logic signed [31:0] m_super [MAX_ROWS];
  logic signed [31:0] m_rhs   [MAX_ROWS];
  int                 m_rows;
  logic [1:0]         m_flags;

  solution_t solution_q[$];
  int        err_cnt;
  int        rows_sent;
  int        systems_sent;
  int        words_checked;
  int        burst_left;
  int        hold_cycles;
  int        idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- fixed-point mirror ----------------
  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > longint'(32'sh7fff_ffff)) begin
      m_flags[1] = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -longint'(64'sd2147483648)) begin
      m_flags[1] = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return clamp32(longint'(a) - longint'(b));
  endfunction

  function automatic logic signed [31:0] q_div(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    if (b == 0) begin
      m_flags[0] = 1'b1;
      return 0;
    end
    return clamp32((longint'(a) * (64'sd1 <<< FRAC_BITS)) / longint'(b));
  endfunction

  task automatic thomas_solve();
    logic signed [31:0] rate;
    solution_t          s;
    logic [1:0]         st;
    for (int i = 0; i + 1 < m_rows; i++) begin
      rate          = q_div(m_sub[i+1], m_diag[i]);
      m_diag[i+1]   = q_sub(m_diag[i+1], q_mul(rate, m_super[i]));
      m_rhs[i+1]    = q_sub(m_rhs[i+1], q_mul(rate, m_rhs[i]));
      m_sub[i+1]    = 0;
    end
    for (int i = m_rows - 1; i >= 1; i--) begin
      rate          = q_div(m_super[i-1], m_diag[i]);
      m_rhs[i-1]    = q_sub(m_rhs[i-1], q_mul(rate, m_rhs[i]));
      m_super[i-1]  = 0;
    end
    for (int i = 0; i < m_rows; i++)
      m_rhs[i] = q_div(m_rhs[i], m_diag[i]);
    st = m_flags[0] ? ST_ZERO : (m_flags[1] ? ST_SAT : ST_OK);
    for (int i = 0; i < m_rows; i++) begin
      s.solution    = m_rhs[i];
      s.row_index   = i[5:0];
      s.last_result = (i + 1 == m_rows);
      s.status      = st;
      solution_q.push_back(s);
    end
    m_rows  = 0;
    m_flags = 2'b00;
  endtask

  task automatic load_row(input logic [31:0] sub, input logic [31:0] dia,
                          input logic [31:0] sup, input logic [31:0] rhs,
                          input logic last);
    int slot;
    slot          = (m_rows < MAX_ROWS) ? m_rows : MAX_ROWS - 1;
    m_sub[slot]   = sub;
    m_diag[slot]  = dia;
    m_super[slot] = sup;
    m_rhs[slot]   = rhs;
    if (m_rows < MAX_ROWS)
      m_rows++;
    if (last) begin
      thomas_solve();
      systems_sent++;
    end
  endtask

  // ---------------- sender ----------------
  task automatic send_row(input logic [31:0] sub, input logic [31:0] dia,
                          input logic [31:0] sup, input logic [31:0] rhs,
                          input logic last);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rhs, sup, dia, sub};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    rows_sent++;
    load_row(sub, dia, sup, rhs, last);
  endtask

  function automatic logic [31:0] q_range(input int lo, input int hi);
    return $urandom_range(hi - lo, 0) + lo;
  endfunction

  // diagonally dominant rows keep the solve mostly unsaturated
  task automatic send_system(input int n, input int wild_pct);
    logic [31:0] sub, dia, sup, rhs;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99, 0) < wild_pct) begin
        sub = $urandom(); dia = $urandom(); sup = $urandom(); rhs = $urandom();
      end else begin
        sub = q_range(-65536, 65536);
        sup = q_range(-65536, 65536);
        dia = q_range(3 * 65536, 8 * 65536);
        if ($urandom_range(1, 0)) dia = -dia;
        rhs = q_range(-100 * 65536, 100 * 65536);
      end
      send_row(sub, dia, sup, rhs, i == n - 1);
    end
  endtask

  // ---------------- receiver ----------------
  initial begin
    int mode, left;
    out_tready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(2, 0);
          left = $urandom_range(80, 10);
        end
        left--;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(1, 0) == 1);
          default: out_tready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  // ---------------- checker ----------------
  always @(posedge clk) begin
    solution_t e;
    if (rst_n && out_tvalid && out_tready) begin
      words_checked++;
      if (solution_q.size() == 0) begin
        $error("solution word with nothing expected: %h", out_tdata);
        err_cnt++;
      end else begin
        e = solution_q.pop_front();
        if (out_tdata[31:0] !== e.solution) begin
          $error("solution: expected %h actual %h", e.solution, out_tdata[31:0]);
          err_cnt++;
        end
        if (out_tdata[37:32] !== e.row_index) begin
          $error("row_index: expected %0d actual %0d", e.row_index, out_tdata[37:32]);
          err_cnt++;
        end
        if (out_tlast !== e.last_result) begin
          $error("last_result: expected %b actual %b", e.last_result, out_tlast);
          err_cnt++;
        end
        if (out_tuser !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_tuser);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb_tridiagonal_system_solver: errors");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_single_row();
    send_row(32'h1234_5678, 32'h0002_0000, 32'h8765_4321, 32'h0003_0000, 1'b1);
    send_row(32'hffff_ffff, 32'hffff_0000, 32'h0000_0000, 32'h7fff_ffff, 1'b1);
    send_row(32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000, 1'b1);
  endtask

  task automatic test_zero_pivot();
    // zero on the first diagonal and a middle pivot that reduces to zero
    send_row(32'h0, 32'h0, 32'h0001_0000, 32'h0005_0000, 1'b0);
    send_row(32'h0001_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000, 1'b1);
    send_row(32'h0, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send_row(32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1'b0);
    send_row(32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0004_0000, 1'b1);
    send_row(32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 1'b1);
  endtask

  task automatic test_saturation();
    send_row(32'h0, 32'h0000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_row(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000, 1'b1);
    // saturation plus a zero pivot: zero pivot wins
    send_row(32'h0, 32'h0000_0001, 32'h0, 32'h7fff_0000, 1'b0);
    send_row(32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_row(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_row(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_row(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0000, 1'b1);
    send_system(3, 0);
  endtask

  // more rows than the store holds: extra rows land in the final slot
  task automatic test_row_overflow();
    send_system(MAX_ROWS + 2, 0);
  endtask

  task automatic test_backpressure();
    hold_cycles = 1500;
    send_system(4, 0);
    send_system(3, 0);
  endtask

  task automatic test_random();
    int goal, n;
    goal = rows_sent + 16;
    while (rows_sent < goal) begin
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 8) : $urandom_range(6, 1);
      send_system(n, ($urandom_range(3, 0) == 0) ? 60 : 10);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    m_rows        = 0;
    m_flags       = 2'b00;
    err_cnt       = 0;
    rows_sent     = 0;
    systems_sent  = 0;
    words_checked = 0;
    burst_left    = 0;
    hold_cycles   = 0;
    idle_cycles   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_row();
    test_zero_pivot();
    test_saturation();
    test_field_extremes();
    test_row_overflow();
    test_backpressure();
    test_random();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d rows in %0d systems; %0d solution words checked.",
             rows_sent, systems_sent, words_checked);
    $display("Covered zero pivots, saturation, row overflow and output hold-off.");
    if (err_cnt == 0)
      $display("tb_tridiagonal_system_solver: clean");
    else
      $display("tb_tridiagonal_system_solver: errors");
    $finish;
  end

endmodule
